@@ design/aus_pkg.sv @@
// Shared types and constants of the angular uniformity statistics block.
// Holds the controller states, arithmetic step codes and control structs.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package aus_pkg;

    // Field widths fixed by the interface.
    localparam int ANGLE_W    = 16;
    localparam int VALUE_W    = 16;
    localparam int RATIO_W    = 16;
    localparam int SPREAD_W   = 20;
    localparam int PTS_W      = 11;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 15;
    localparam int LIMIT_W    = 15;

    // Square root: radicand and root widths.
    localparam int RAD_W  = 128;
    localparam int ROOT_W = 64;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_LIMIT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIDE_LOWER   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIDE_UPPER   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_NORM  = 2'd3;

    // Reset values of the window bounds, 0.01 degree units.
    localparam logic [LIMIT_W-1:0] CENTER_LIMIT_RST = 15'd2000;
    localparam logic [LIMIT_W-1:0] SIDE_LOWER_RST   = 15'd3000;
    localparam logic [LIMIT_W-1:0] SIDE_UPPER_RST   = 15'd7000;

    // Arithmetic constants.
    localparam logic [16:0]         SCALE      = 17'd100000;
    localparam logic [12:0]         ONE_Q      = 13'd4096;
    localparam logic [RATIO_W-1:0]  RATIO_MAX  = 16'hFFFF;
    localparam logic [SPREAD_W-1:0] SPREAD_MAX = 20'hFFFFF;

    // Statistic sets.
    localparam logic [1:0] SET_POOL = 2'd0;
    localparam logic [1:0] SET_X    = 2'd1;
    localparam logic [1:0] SET_Y    = 2'd2;

    typedef enum logic [1:0] {
        S_ACCUM,
        S_ISSUE,
        S_WAIT,
        S_FINISH
    } state_t;

    // Arithmetic steps run for each set, in this order.
    typedef enum logic [3:0] {
        STEP_NUM,
        STEP_DEN,
        STEP_RATIO,
        STEP_SQA,
        STEP_SQB,
        STEP_KSC,
        STEP_MSC,
        STEP_E,
        STEP_P,
        STEP_ROOT,
        STEP_QUOT
    } step_t;

    typedef struct packed {
        logic       accum;
        logic       start;
        step_t      step;
        logic [1:0] set_sel;
        logic       load_out;
        logic       clear;
    } cmd_t;

    typedef struct packed {
        logic done;
    } stat_t;

endpackage

@@ design/aus_ctrl.sv @@
// Controller of the angular uniformity statistics block.
// Sequences accumulation, the per-set arithmetic steps and the result hand-off.
// Depends on aus_pkg.
`timescale 1ns / 1ps

module aus_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_last,
    output logic           in_ready,
    input  logic           out_ready,
    output logic           out_valid,
    output aus_pkg::cmd_t  cmd,
    input  aus_pkg::stat_t stat
);
    import aus_pkg::*;

    state_t     state_reg, state_next;
    step_t      step_reg, step_next;
    logic [1:0] set_reg, set_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACCUM;
            step_reg      <= STEP_NUM;
            set_reg       <= SET_POOL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            set_reg       <= set_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        set_next     = set_reg;
        cmd          = '0;
        cmd.step     = step_reg;
        cmd.set_sel  = set_reg;
        in_ready     = (state_reg == S_ACCUM);
        case (state_reg)
            S_ACCUM:
            begin
                if (in_valid)
                begin
                    cmd.accum = 1'b1;
                    if (in_last)
                    begin
                        step_next  = STEP_NUM;
                        set_next   = SET_POOL;
                        state_next = S_ISSUE;
                    end
                end
            end
            S_ISSUE:
            begin
                cmd.start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (stat.done)
                begin
                    if (step_reg == STEP_QUOT)
                    begin
                        if (set_reg == SET_Y)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            set_next   = set_reg + 2'd1;
                            step_next  = STEP_NUM;
                            state_next = S_ISSUE;
                        end
                    end
                    else
                    begin
                        step_next  = step_t'(step_reg + 4'd1);
                        state_next = S_ISSUE;
                    end
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = S_ACCUM;
                end
            end
            default:
            begin
                state_next = S_ACCUM;
            end
        endcase
        out_valid_next = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    assign out_valid = out_valid_reg;

endmodule

@@ design/aus_dp.sv @@
// Datapath of the angular uniformity statistics block: configuration
// registers, per-axis accumulators, shift-add multiplier, restoring divider,
// digit-by-digit square root and the result register. Depends on aus_pkg.
`timescale 1ns / 1ps

module aus_dp #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [aus_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [aus_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic signed [aus_pkg::ANGLE_W-1:0] angle,
    input  logic [aus_pkg::VALUE_W-1:0]       value,
    input  logic                              axis,
    input  aus_pkg::cmd_t                     cmd,
    output aus_pkg::stat_t                    stat,
    output logic                              pooled_ok,
    output logic [aus_pkg::RATIO_W-1:0]       pooled_ratio,
    output logic [aus_pkg::SPREAD_W-1:0]      pooled_spread,
    output logic                              x_ok,
    output logic [aus_pkg::RATIO_W-1:0]       x_ratio,
    output logic [aus_pkg::SPREAD_W-1:0]      x_spread,
    output logic                              y_ok,
    output logic [aus_pkg::RATIO_W-1:0]       y_ratio,
    output logic [aus_pkg::SPREAD_W-1:0]      y_spread,
    output logic [aus_pkg::PTS_W-1:0]         x_points,
    output logic [aus_pkg::PTS_W-1:0]         y_points
);
    import aus_pkg::*;

    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int PCW   = CW + 1;
    localparam int SW    = CW + 16;
    localparam int PSW   = SW + 1;
    localparam int QW    = CW + 32;
    localparam int PQW   = QW + 1;
    localparam int BW    = PCW + 18;
    localparam int NW    = PSW + PCW;
    localparam int AW    = PCW + PQW;
    localparam int BBW   = 2 * PSW;
    localparam int MAW   = AW + BW;
    localparam int PW    = MAW + BW;
    localparam int XW    = (PW > RAD_W) ? PW : RAD_W;
    localparam int DVW   = (2 * CW + 32 > ROOT_W) ? 2 * CW + 32 : ROOT_W;
    localparam int SRW   = ROOT_W + 3;
    localparam int LEN_W = $clog2(DVW + 1);

    // Configuration.
    logic [LIMIT_W-1:0] center_limit_reg, side_lower_reg, side_upper_reg;
    logic               center_norm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_limit_reg <= CENTER_LIMIT_RST;
            side_lower_reg   <= SIDE_LOWER_RST;
            side_upper_reg   <= SIDE_UPPER_RST;
            center_norm_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_CENTER_LIMIT: center_limit_reg <= cfg_wdata;
                CFG_SIDE_LOWER:   side_lower_reg   <= cfg_wdata;
                CFG_SIDE_UPPER:   side_upper_reg   <= cfg_wdata;
                CFG_CENTER_NORM:  center_norm_reg  <= cfg_wdata[0];
                default:          center_norm_reg  <= center_norm_reg;
            endcase
        end
    end

    // Per-axis accumulators.
    logic [CW-1:0] pc_reg [2], pc_next [2];
    logic [CW-1:0] cc_reg [2], cc_next [2];
    logic [SW-1:0] cs_reg [2], cs_next [2];
    logic [CW-1:0] sc_reg [2], sc_next [2];
    logic [SW-1:0] ss_reg [2], ss_next [2];
    logic [CW-1:0] nc_reg [2], nc_next [2];
    logic [SW-1:0] ns_reg [2], ns_next [2];
    logic [QW-1:0] nq_reg [2], nq_next [2];

    logic [16:0] mag;
    logic [31:0] vsq;
    logic        sample_ok, in_center, in_side, in_spread;

    assign mag       = angle[15] ? (17'h10000 - {1'b0, angle}) : {1'b0, angle};
    assign vsq       = 32'(value) * 32'(value);
    assign sample_ok = (value != '0) && (pc_reg[axis] < CW'(MAX_POINTS));
    assign in_center = mag < {2'b00, center_limit_reg};
    assign in_side   = (mag > {2'b00, side_lower_reg}) && (mag < {2'b00, side_upper_reg});
    assign in_spread = mag < {2'b00, side_upper_reg};

    always_comb
    begin
        pc_next = pc_reg;
        cc_next = cc_reg;
        cs_next = cs_reg;
        sc_next = sc_reg;
        ss_next = ss_reg;
        nc_next = nc_reg;
        ns_next = ns_reg;
        nq_next = nq_reg;
        if (cmd.clear)
        begin
            pc_next = '{default: '0};
            cc_next = '{default: '0};
            cs_next = '{default: '0};
            sc_next = '{default: '0};
            ss_next = '{default: '0};
            nc_next = '{default: '0};
            ns_next = '{default: '0};
            nq_next = '{default: '0};
        end
        else if (cmd.accum && sample_ok)
        begin
            pc_next[axis] = pc_reg[axis] + CW'(1);
            if (in_center)
            begin
                cc_next[axis] = cc_reg[axis] + CW'(1);
                cs_next[axis] = cs_reg[axis] + SW'(value);
            end
            if (in_side)
            begin
                sc_next[axis] = sc_reg[axis] + CW'(1);
                ss_next[axis] = ss_reg[axis] + SW'(value);
            end
            if (in_spread)
            begin
                nc_next[axis] = nc_reg[axis] + CW'(1);
                ns_next[axis] = ns_reg[axis] + SW'(value);
                nq_next[axis] = nq_reg[axis] + QW'(vsq);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '{default: '0};
            cc_reg <= '{default: '0};
            cs_reg <= '{default: '0};
            sc_reg <= '{default: '0};
            ss_reg <= '{default: '0};
            nc_reg <= '{default: '0};
            ns_reg <= '{default: '0};
            nq_reg <= '{default: '0};
        end
        else
        begin
            pc_reg <= pc_next;
            cc_reg <= cc_next;
            cs_reg <= cs_next;
            sc_reg <= sc_next;
            ss_reg <= ss_next;
            nc_reg <= nc_next;
            ns_reg <= ns_next;
            nq_reg <= nq_next;
        end
    end

    // Pooled sums and the operands of the selected set.
    logic [PCW-1:0] p_cc, p_sc, p_n;
    logic [PSW-1:0] p_cs, p_ss, p_s;
    logic [PQW-1:0] p_s2;
    logic [PCW-1:0] sel_cc, sel_sc, sel_n;
    logic [PSW-1:0] sel_cs, sel_ss, sel_s;
    logic [PQW-1:0] sel_s2;
    logic           norm, ok_pool, ok_x, ok_y;

    assign p_cc = PCW'(cc_reg[0]) + PCW'(cc_reg[1]);
    assign p_sc = PCW'(sc_reg[0]) + PCW'(sc_reg[1]);
    assign p_n  = PCW'(nc_reg[0]) + PCW'(nc_reg[1]);
    assign p_cs = PSW'(cs_reg[0]) + PSW'(cs_reg[1]);
    assign p_ss = PSW'(ss_reg[0]) + PSW'(ss_reg[1]);
    assign p_s  = PSW'(ns_reg[0]) + PSW'(ns_reg[1]);
    assign p_s2 = PQW'(nq_reg[0]) + PQW'(nq_reg[1]);
    assign norm = center_norm_reg && (p_cc != '0);

    assign ok_pool = (p_cc != '0) && (p_sc != '0) && (p_n >= PCW'(2));
    assign ok_x    = (cc_reg[0] != '0) && (sc_reg[0] != '0) && (nc_reg[0] >= CW'(2));
    assign ok_y    = (cc_reg[1] != '0) && (sc_reg[1] != '0) && (nc_reg[1] >= CW'(2));

    always_comb
    begin
        case (cmd.set_sel)
            SET_X:
            begin
                sel_cc = PCW'(cc_reg[0]);
                sel_cs = PSW'(cs_reg[0]);
                sel_sc = PCW'(sc_reg[0]);
                sel_ss = PSW'(ss_reg[0]);
                sel_n  = PCW'(nc_reg[0]);
                sel_s  = PSW'(ns_reg[0]);
                sel_s2 = PQW'(nq_reg[0]);
            end
            SET_Y:
            begin
                sel_cc = PCW'(cc_reg[1]);
                sel_cs = PSW'(cs_reg[1]);
                sel_sc = PCW'(sc_reg[1]);
                sel_ss = PSW'(ss_reg[1]);
                sel_n  = PCW'(nc_reg[1]);
                sel_s  = PSW'(ns_reg[1]);
                sel_s2 = PQW'(nq_reg[1]);
            end
            default:
            begin
                sel_cc = p_cc;
                sel_cs = p_cs;
                sel_sc = p_sc;
                sel_ss = p_ss;
                sel_n  = p_n;
                sel_s  = p_s;
                sel_s2 = p_s2;
            end
        endcase
    end

    // Intermediate results of the steps.
    logic [NW-1:0]     r_num_reg, r_den_reg, r_m_reg;
    logic [AW-1:0]     r_a_reg;
    logic [BBW-1:0]    r_b_reg;
    logic [BW-1:0]     r_k2_reg;
    logic [MAW-1:0]    r_e_reg;
    logic [RAD_W-1:0]  r_p_reg;
    logic [ROOT_W-1:0] r_t_reg;
    logic [RATIO_W-1:0]  ratio_reg  [3];
    logic [SPREAD_W-1:0] spread_reg [3];

    // Operand selection for the unit that the step uses.
    logic           use_div, use_sqrt;
    logic [MAW-1:0] mul_a;
    logic [BW-1:0]  mul_b;
    logic [DVW-1:0] div_n, div_d;

    assign use_div  = (cmd.step == STEP_RATIO) || (cmd.step == STEP_QUOT);
    assign use_sqrt = (cmd.step == STEP_ROOT);

    always_comb
    begin
        mul_a = MAW'(sel_cs);
        mul_b = BW'(sel_sc);
        div_n = DVW'(r_t_reg);
        div_d = DVW'({r_m_reg, 1'b0});
        case (cmd.step)
            STEP_DEN:
            begin
                mul_a = MAW'(sel_ss);
                mul_b = BW'(sel_cc);
            end
            STEP_SQA:
            begin
                mul_a = MAW'(sel_s2);
                mul_b = BW'(sel_n);
            end
            STEP_SQB:
            begin
                mul_a = MAW'(sel_s);
                mul_b = BW'(sel_s);
            end
            STEP_KSC:
            begin
                mul_a = MAW'(SCALE);
                mul_b = norm ? BW'(p_cc) : BW'(1);
            end
            STEP_MSC:
            begin
                mul_a = norm ? MAW'(p_cs) : MAW'(ONE_Q);
                mul_b = BW'(sel_n);
            end
            STEP_E:
            begin
                mul_a = MAW'(r_a_reg - AW'(r_b_reg));
                mul_b = r_k2_reg;
            end
            STEP_P:
            begin
                mul_a = r_e_reg;
                mul_b = r_k2_reg;
            end
            STEP_RATIO:
            begin
                div_n = DVW'({r_num_reg, 13'b0}) + DVW'(r_den_reg);
                div_d = DVW'({r_den_reg, 1'b0});
            end
            default:
            begin
                mul_a = MAW'(sel_cs);
            end
        endcase
    end

    // Iterative units: one multiplier bit, one quotient bit or one root bit per cycle.
    logic [PW-1:0]     mc_reg, mc_next, ma_reg, ma_next;
    logic [BW-1:0]     mp_reg, mp_next;
    logic [DVW-1:0]    dq_reg, dq_next, dd_reg, dd_next;
    logic [DVW:0]      dr_reg, dr_next, div_trial;
    logic [RAD_W-1:0]  sqs_reg, sqs_next;
    logic [SRW-1:0]    sqr_reg, sqr_next, sq_rem2, sq_trial;
    logic [ROOT_W-1:0] sqt_reg, sqt_next;
    logic              busy_reg, busy_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;

    assign div_trial = {dr_reg[DVW-1:0], dq_reg[DVW-1]};
    assign sq_rem2   = {sqr_reg[SRW-3:0], sqs_reg[RAD_W-1:RAD_W-2]};
    assign sq_trial  = {1'b0, sqt_reg, 2'b01};

    always_comb
    begin
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        ma_next   = ma_reg;
        dq_next   = dq_reg;
        dr_next   = dr_reg;
        dd_next   = dd_reg;
        sqs_next  = sqs_reg;
        sqr_next  = sqr_reg;
        sqt_next  = sqt_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        stat      = '0;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            if (use_div)
            begin
                dq_next  = div_n;
                dd_next  = div_d;
                dr_next  = '0;
                cnt_next = LEN_W'(DVW);
            end
            else if (use_sqrt)
            begin
                sqs_next = r_p_reg;
                sqr_next = '0;
                sqt_next = '0;
                cnt_next = LEN_W'(ROOT_W);
            end
            else
            begin
                mc_next  = PW'(mul_a);
                mp_next  = mul_b;
                ma_next  = '0;
                cnt_next = LEN_W'(BW);
            end
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                stat.done = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - LEN_W'(1);
                if (use_div)
                begin
                    if (div_trial >= {1'b0, dd_reg})
                    begin
                        dr_next = div_trial - {1'b0, dd_reg};
                        dq_next = {dq_reg[DVW-2:0], 1'b1};
                    end
                    else
                    begin
                        dr_next = div_trial;
                        dq_next = {dq_reg[DVW-2:0], 1'b0};
                    end
                end
                else if (use_sqrt)
                begin
                    sqs_next = {sqs_reg[RAD_W-3:0], 2'b00};
                    if (sq_rem2 >= sq_trial)
                    begin
                        sqr_next = sq_rem2 - sq_trial;
                        sqt_next = {sqt_reg[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        sqr_next = sq_rem2;
                        sqt_next = {sqt_reg[ROOT_W-2:0], 1'b0};
                    end
                end
                else
                begin
                    if (mp_reg[0])
                    begin
                        ma_next = ma_reg + mc_reg;
                    end
                    mc_next = {mc_reg[PW-2:0], 1'b0};
                    mp_next = {1'b0, mp_reg[BW-1:1]};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
        ma_reg  <= ma_next;
        dq_reg  <= dq_next;
        dr_reg  <= dr_next;
        dd_reg  <= dd_next;
        sqs_reg <= sqs_next;
        sqr_reg <= sqr_next;
        sqt_reg <= sqt_next;
    end

    // Result write-back when a unit finishes.
    logic [XW-1:0]  prod_ext;
    logic           prod_ovf, round_up;
    logic [DVW:0]   spread_q;

    assign prod_ext = XW'(ma_reg);
    assign prod_ovf = (prod_ext >> RAD_W) != '0;
    assign round_up = dr_reg >= (DVW + 1)'(r_m_reg);
    assign spread_q = (DVW + 1)'(dq_reg) + (DVW + 1)'(round_up);

    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            case (cmd.step)
                STEP_NUM:   r_num_reg <= NW'(ma_reg);
                STEP_DEN:   r_den_reg <= NW'(ma_reg);
                STEP_SQA:   r_a_reg   <= AW'(ma_reg);
                STEP_SQB:   r_b_reg   <= BBW'(ma_reg);
                STEP_KSC:   r_k2_reg  <= BW'({ma_reg, 1'b0});
                STEP_MSC:   r_m_reg   <= NW'(ma_reg);
                STEP_E:     r_e_reg   <= MAW'(ma_reg);
                STEP_P:     r_p_reg   <= prod_ovf ? '1 : prod_ext[RAD_W-1:0];
                STEP_ROOT:  r_t_reg   <= sqt_reg;
                STEP_RATIO: ratio_reg[cmd.set_sel] <= (dq_reg > DVW'(RATIO_MAX)) ?
                                RATIO_MAX : dq_reg[RATIO_W-1:0];
                STEP_QUOT:  spread_reg[cmd.set_sel] <= (spread_q > (DVW + 1)'(SPREAD_MAX)) ?
                                SPREAD_MAX : spread_q[SPREAD_W-1:0];
                default:    r_t_reg   <= r_t_reg;
            endcase
        end
    end

    // Result register; fields of an invalid set read as zero.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            pooled_ok     <= ok_pool;
            pooled_ratio  <= ok_pool ? ratio_reg[SET_POOL]  : '0;
            pooled_spread <= ok_pool ? spread_reg[SET_POOL] : '0;
            x_ok          <= ok_x;
            x_ratio       <= ok_x ? ratio_reg[SET_X]  : '0;
            x_spread      <= ok_x ? spread_reg[SET_X] : '0;
            y_ok          <= ok_y;
            y_ratio       <= ok_y ? ratio_reg[SET_Y]  : '0;
            y_spread      <= ok_y ? spread_reg[SET_Y] : '0;
            x_points      <= PTS_W'(pc_reg[0]);
            y_points      <= PTS_W'(pc_reg[1]);
        end
    end

endmodule

@@ design/angular_uniformity_stats.sv @@
// After the closing sample the result appears once the arithmetic steps have run for the pooled,
// X and Y sets in turn.
// Throughput: one sample per cycle within a scan; the bit-serial multiplier, divider and root
// in the datapath, and a previous result not yet taken on the result stream, set the time
// from the closing sample until the next scan is accepted.
// Reset (rst_n, asynchronous, active low) restores the default windows and clears all sums.
`timescale 1ns / 1ps

module angular_uniformity_stats #(
    parameter int MAX_POINTS = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    // Configuration write port.
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [14:0]  cfg_wdata,
    // Sample stream.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // angle [15:0], value [31:16]
    input  logic         s_axis_tuser,   // axis: 0 X, 1 Y
    input  logic         s_axis_tlast,   // closes the scan
    // Result stream.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata    // pooled_ok, pooled_ratio, pooled_spread, x_ok,
                                         // x_ratio, x_spread, y_ok, y_ratio, y_spread,
                                         // x_points, y_points, zero fill
);
    import aus_pkg::*;

    cmd_t  ctl_cmd;
    stat_t dp_stat;

    logic                pooled_ok, x_ok, y_ok;
    logic [RATIO_W-1:0]  pooled_ratio, x_ratio, y_ratio;
    logic [SPREAD_W-1:0] pooled_spread, x_spread, y_spread;
    logic [PTS_W-1:0]    x_points, y_points;

    // The controller owns the handshakes; each accepted request is accumulated
    // at once, and the closing request starts the arithmetic sequence.
    aus_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .cmd       (ctl_cmd),
        .stat      (dp_stat)
    );

    // The datapath holds configuration, accumulators, the serial units and
    // the result register that keeps a finished result while a new scan runs.
    aus_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .angle         (s_axis_tdata[15:0]),
        .value         (s_axis_tdata[31:16]),
        .axis          (s_axis_tuser),
        .cmd           (ctl_cmd),
        .stat          (dp_stat),
        .pooled_ok     (pooled_ok),
        .pooled_ratio  (pooled_ratio),
        .pooled_spread (pooled_spread),
        .x_ok          (x_ok),
        .x_ratio       (x_ratio),
        .x_spread      (x_spread),
        .y_ok          (y_ok),
        .y_ratio       (y_ratio),
        .y_spread      (y_spread),
        .x_points      (x_points),
        .y_points      (y_points)
    );

    // Fields packed from the lowest bit up, padded to whole bytes.
    assign m_axis_tdata = {3'b000, y_points, x_points,
                           y_spread, y_ratio, y_ok,
                           x_spread, x_ratio, x_ok,
                           pooled_spread, pooled_ratio, pooled_ok};

`ifndef ASSERT_OFF
    // No sample may be taken while an arithmetic step is launched.
    a_no_accept_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.start |-> !s_axis_tready)
        else $error("sample accepted during arithmetic");

    // A new result only appears after the result register was loaded.
    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(ctl_cmd.load_out))
        else $error("result valid without load");

    // A unit never completes in the cycle that another one starts.
    a_done_not_start: assert property (@(posedge clk) disable iff (!rst_n)
        dp_stat.done |-> !ctl_cmd.start)
        else $error("unit start overlaps completion");

    // Loading a result always clears the sums for the next scan.
    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.load_out |-> ctl_cmd.clear && !ctl_cmd.accum)
        else $error("result loaded without clearing");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench of the angular uniformity statistics block.
// Drives scans of samples and checks every scan result against a predictor or a typed value.
// Depends on aus_pkg and the angular_uniformity_stats RTL.
`timescale 1ns / 1ps

module tb_top;
    import aus_pkg::*;

    localparam int MAX_PTS = 1024;
    localparam longint CYCLE_LIMIT = 20000000;
    localparam int DRAIN_CYCLES = 1500;

    // One result request; pooled_ok, the last field declared, sits in the lowest bits.
    typedef struct packed {
        logic [2:0]  fill;
        logic [10:0] y_points;
        logic [10:0] x_points;
        logic [19:0] y_spread;
        logic [15:0] y_ratio;
        logic        y_ok;
        logic [19:0] x_spread;
        logic [15:0] x_ratio;
        logic        x_ok;
        logic [19:0] pooled_spread;
        logic [15:0] pooled_ratio;
        logic        pooled_ok;
    } scan_result_t;

    // One row of the directed table. When fixed is set the expected result is
    // typed in the row; otherwise the predictor supplies it.
    typedef struct {
        logic [15:0]  angle;
        logic [15:0]  value;
        logic         axis;
        logic         last;
        bit           fixed;
        scan_result_t result;
    } sample_row_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_addr;
    logic [14:0]  cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;   // angle [15:0], value [31:16]
    logic         s_axis_tuser;   // axis: 0 X, 1 Y
    logic         s_axis_tlast;   // closes the scan
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;   // pooled_ok, pooled_ratio, pooled_spread, x_ok, x_ratio,
                                  // x_spread, y_ok, y_ratio, y_spread, x_points, y_points

    angular_uniformity_stats #(.MAX_POINTS(MAX_PTS)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predictor copy of the registers and the per-axis accumulators.
    logic [14:0] win_center;
    logic [14:0] win_side_lo;
    logic [14:0] win_side_hi;
    logic        norm_on;
    bit [63:0]   acc_points[2];
    bit [63:0]   acc_cc[2];
    bit [63:0]   acc_cs[2];
    bit [63:0]   acc_sc[2];
    bit [63:0]   acc_ss[2];
    bit [63:0]   acc_n[2];
    bit [63:0]   acc_s[2];
    bit [63:0]   acc_s2[2];

    scan_result_t scan_results_due[$];
    int           mismatches;
    longint       cycles;
    int           hold_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: a run that hangs is a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic void clear_sums();
        for (int a = 0; a < 2; a++)
        begin
            acc_points[a] = 0;
            acc_cc[a] = 0;
            acc_cs[a] = 0;
            acc_sc[a] = 0;
            acc_ss[a] = 0;
            acc_n[a] = 0;
            acc_s[a] = 0;
            acc_s2[a] = 0;
        end
    endfunction

    // Population deviation, scaled by k/m and rounded half up:
    // round(k * sqrt(n*s2 - s*s) / m), computed exactly with an integer root.
    function automatic logic [19:0] deviation_scaled(bit [63:0] n, bit [63:0] s,
                                                     bit [63:0] s2, bit [63:0] k,
                                                     bit [63:0] m);
        bit [127:0] a;
        bit [127:0] b;
        bit [255:0] p;
        bit [127:0] rad;
        bit [63:0]  root;
        bit [63:0]  cand;
        bit [127:0] q;
        a = 128'(n) * 128'(s2);
        b = 128'(s) * 128'(s);
        if (m == 0)
            return SPREAD_MAX;
        if (b > a)
            return 0;
        p = 256'(2 * k) * 256'(a - b) * 256'(2 * k);
        rad = (p[255:128] != 0) ? {128{1'b1}} : p[127:0];
        root = 0;
        for (int bit_i = 63; bit_i >= 0; bit_i--)
        begin
            cand = root | (64'd1 << bit_i);
            if (128'(cand) * 128'(cand) <= rad)
                root = cand;
        end
        q = 128'(root / (2 * m)) + (((root % (2 * m)) >= m) ? 128'd1 : 128'd0);
        return (q > 128'(SPREAD_MAX)) ? SPREAD_MAX : q[19:0];
    endfunction

    // Statistics of one set of accumulators: validity, ratio and deviation.
    function automatic void set_statistics(bit [63:0] cc, bit [63:0] cs, bit [63:0] sc,
                                           bit [63:0] ss, bit [63:0] n, bit [63:0] s,
                                           bit [63:0] s2, bit [63:0] pool_cc,
                                           bit [63:0] pool_cs, output logic ok,
                                           output logic [15:0] ratio,
                                           output logic [19:0] spread);
        bit [63:0] k;
        bit [63:0] m;
        bit [63:0] num;
        bit [63:0] den;
        bit [63:0] q;
        k = 100000;
        m = 4096 * n;
        ok = 1'b0;
        ratio = '0;
        spread = '0;
        if (cc == 0 || sc == 0 || n < 2)
            return;
        if (norm_on && pool_cc != 0 && pool_cs != 0)
        begin
            k = 100000 * pool_cc;
            m = n * pool_cs;
        end
        ok = 1'b1;
        if (ss != 0)
        begin
            num = cs * sc;
            den = cc * ss;
            q = (num * 8192 + den) / (2 * den);
            ratio = (q > 64'(RATIO_MAX)) ? RATIO_MAX : q[15:0];
        end
        spread = deviation_scaled(n, s, s2, k, m);
    endfunction

    // Accumulates one accepted sample; returns 1 and fills the result on the
    // closing sample, after which the sums clear.
    function automatic bit scan_predict(logic [15:0] angle, logic [15:0] value,
                                        logic axis, logic last,
                                        output scan_result_t res);
        bit [16:0] mag;
        bit [63:0] pcc;
        bit [63:0] pcs;
        int        a;
        a = axis;
        mag = angle[15] ? (17'h10000 - 17'(angle)) : 17'(angle);
        res = '0;
        if (value != 0 && acc_points[a] < MAX_PTS)
        begin
            acc_points[a]++;
            if (mag < win_center)
            begin
                acc_cc[a]++;
                acc_cs[a] += value;
            end
            if (mag > win_side_lo && mag < win_side_hi)
            begin
                acc_sc[a]++;
                acc_ss[a] += value;
            end
            if (mag < win_side_hi)
            begin
                acc_n[a]++;
                acc_s[a] += value;
                acc_s2[a] += 64'(value) * 64'(value);
            end
        end
        if (!last)
            return 0;
        pcc = acc_cc[0] + acc_cc[1];
        pcs = acc_cs[0] + acc_cs[1];
        set_statistics(pcc, pcs, acc_sc[0] + acc_sc[1], acc_ss[0] + acc_ss[1],
                       acc_n[0] + acc_n[1], acc_s[0] + acc_s[1], acc_s2[0] + acc_s2[1],
                       pcc, pcs, res.pooled_ok, res.pooled_ratio, res.pooled_spread);
        set_statistics(acc_cc[0], acc_cs[0], acc_sc[0], acc_ss[0], acc_n[0], acc_s[0],
                       acc_s2[0], pcc, pcs, res.x_ok, res.x_ratio, res.x_spread);
        set_statistics(acc_cc[1], acc_cs[1], acc_sc[1], acc_ss[1], acc_n[1], acc_s[1],
                       acc_s2[1], pcc, pcs, res.y_ok, res.y_ratio, res.y_spread);
        res.x_points = acc_points[0][10:0];
        res.y_points = acc_points[1][10:0];
        clear_sums();
        return 1;
    endfunction

    function automatic void check_field(string label, logic [19:0] want, logic [19:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d, got %0d", label, want, got);
        end
    endfunction

    // Result side: random ready with short and occasional long stalls, plus a
    // hold-off on request of the stimulus; every accepted result is checked.
    initial
    begin
        int stall_left;
        scan_result_t want;
        scan_result_t got;
        stall_left = 0;
        m_axis_tready = 1'b0;
        hold_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (scan_results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result request %h", m_axis_tdata);
                end
                else
                begin
                    want = scan_results_due.pop_front();
                    check_field("pooled_ok", want.pooled_ok, got.pooled_ok);
                    check_field("pooled_ratio", want.pooled_ratio, got.pooled_ratio);
                    check_field("pooled_spread", want.pooled_spread, got.pooled_spread);
                    check_field("x_ok", want.x_ok, got.x_ok);
                    check_field("x_ratio", want.x_ratio, got.x_ratio);
                    check_field("x_spread", want.x_spread, got.x_spread);
                    check_field("y_ok", want.y_ok, got.y_ok);
                    check_field("y_ratio", want.y_ratio, got.y_ratio);
                    check_field("y_spread", want.y_spread, got.y_spread);
                    check_field("x_points", want.x_points, got.x_points);
                    check_field("y_points", want.y_points, got.y_points);
                    check_field("fill", want.fill, got.fill);
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if ($urandom_range(99) < 70)
                m_axis_tready <= 1'b1;
            else
            begin
                m_axis_tready <= 1'b0;
                stall_left = ($urandom_range(9) == 0) ? $urandom_range(100, 20)
                                                      : $urandom_range(3, 0);
            end
        end
    end

    // Writes one register at the next clock edge and updates the predictor copy.
    task automatic write_reg(logic [1:0] idx, logic [14:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CENTER_LIMIT: win_center = data;
            CFG_SIDE_LOWER:   win_side_lo = data;
            CFG_SIDE_UPPER:   win_side_hi = data;
            CFG_CENTER_NORM:  norm_on = data[0];
        endcase
    endtask

    task automatic write_windows(logic [14:0] c, logic [14:0] lo, logic [14:0] hi,
                                 logic [14:0] norm);
        write_reg(CFG_CENTER_LIMIT, c);
        write_reg(CFG_SIDE_LOWER, lo);
        write_reg(CFG_SIDE_UPPER, hi);
        write_reg(CFG_CENTER_NORM, norm);
    endtask

    // Blocks until every scan result has been taken; every phase ends on a
    // closing sample, so the block is idle afterwards. The sample side stops
    // offering first so the last request is not taken again.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (scan_results_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Offers one sample request and waits for it to be taken. When fixed is
    // set the typed result replaces the predicted one.
    task automatic send_sample(logic [15:0] angle, logic [15:0] value, logic axis,
                               logic last, bit fixed, scan_result_t typed, bit may_idle);
        scan_result_t res;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {value, angle};
        s_axis_tuser <= axis;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (scan_predict(angle, value, axis, last, res))
            scan_results_due.insert(scan_results_due.size(), fixed ? typed : res);
        // Valid stays high into the next request unless a gap is drawn here.
        if (may_idle && $urandom_range(99) < 30)
        begin
            s_axis_tvalid <= 1'b0;
            gap = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [15:0] draw_angle();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return 16'($urandom);
        else if (r < 20)
            return (r < 18) ? 16'h8000 : 16'h7FFF;
        return 16'($signed($urandom_range(2 * 9000, 0)) - 9000);
    endfunction

    function automatic logic [15:0] draw_value();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return 16'd0;
        else if (r < 12)
            return 16'hFFFF;
        else if (r < 15)
            return 16'd1;
        else if (r < 50)
            return 16'($urandom);
        return 16'($urandom_range(6000, 2500));
    endfunction

    initial
    begin
        sample_row_t  rows[$];
        sample_row_t  row;
        scan_result_t typed;
        scan_result_t none;
        int           sent;
        int           len;
        int           scans;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        mismatches = 0;
        cycles = 0;
        none = '0;
        win_center = CENTER_LIMIT_RST;
        win_side_lo = SIDE_LOWER_RST;
        win_side_hi = SIDE_UPPER_RST;
        norm_on = 1'b0;
        clear_sums();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed table, on the reset windows.
        // A lone sample: one point, every set invalid.
        typed = '0;
        typed.x_points = 11'd1;
        rows.insert(rows.size(), '{16'd0, 16'd4096, 1'b0, 1'b1, 1, typed});
        // A scan of one zero sample: dropped, an empty result.
        rows.insert(rows.size(), '{16'd0, 16'd0, 1'b1, 1'b1, 1, '0});
        // A mixed scan across both axes and all windows, with the most
        // negative angle, the largest positive pattern and value extremes.
        rows.insert(rows.size(), '{16'd0, 16'd4096, 1'b0, 1'b0, 0, none});
        rows.insert(rows.size(), '{16'd4000, 16'd2048, 1'b0, 1'b0, 0, none});
        rows.insert(rows.size(), '{-16'sd4000, 16'd8192, 1'b1, 1'b0, 0, none});
        rows.insert(rows.size(), '{16'd100, 16'hFFFF, 1'b1, 1'b0, 0, none});
        rows.insert(rows.size(), '{16'h8000, 16'd1, 1'b0, 1'b0, 0, none});
        rows.insert(rows.size(), '{16'h7FFF, 16'd300, 1'b1, 1'b0, 0, none});
        rows.insert(rows.size(), '{-16'sd100, 16'd5000, 1'b0, 1'b0, 0, none});
        rows.insert(rows.size(), '{16'd6999, 16'd1, 1'b0, 1'b0, 0, none});
        rows.insert(rows.size(), '{16'd3001, 16'hFFFF, 1'b1, 1'b0, 0, none});
        rows.insert(rows.size(), '{16'd3000, 16'd700, 1'b0, 1'b0, 0, none});
        rows.insert(rows.size(), '{16'd1999, 16'd9000, 1'b1, 1'b0, 0, none});
        rows.insert(rows.size(), '{16'd18000, 16'd1000, 1'b0, 1'b0, 0, none});
        rows.insert(rows.size(), '{-16'sd18000, 16'd0, 1'b1, 1'b0, 0, none});
        rows.insert(rows.size(), '{16'd5000, 16'd3000, 1'b0, 1'b1, 0, none});
        // Centre only, no side points: invalid, ratio and deviation zero.
        typed = '0;
        typed.y_points = 11'd2;
        rows.insert(rows.size(), '{16'd10, 16'd4096, 1'b1, 1'b0, 1, none});
        rows.insert(rows.size(), '{16'd20, 16'd4096, 1'b1, 1'b1, 1, typed});
        foreach (rows[i])
        begin
            row = rows[i];
            send_sample(row.angle, row.value, row.axis, row.last, row.fixed, row.result, 1);
        end
        drain_results();

        // Normalised deviations on the reset windows.
        write_windows(15'd2000, 15'd3000, 15'd7000, 15'd1);
        send_sample(16'd0, 16'd4096, 1'b0, 1'b0, 0, none, 1);
        send_sample(16'd4000, 16'd2000, 1'b1, 1'b0, 0, none, 1);
        send_sample(16'd5000, 16'd6000, 1'b0, 1'b0, 0, none, 1);
        send_sample(-16'sd10, 16'd100, 1'b1, 1'b1, 0, none, 1);
        drain_results();

        // Capacity: more X points than the block holds in one scan.
        write_windows(15'd18000, 15'd0, 15'd18000, 15'd0);
        for (int i = 0; i <= MAX_PTS + 3; i++)
            send_sample(16'($signed($urandom_range(16000, 0)) - 8000), draw_value() | 16'd1,
                        1'b0, i == MAX_PTS + 3, 0, none, 0);
        drain_results();

        // Random scans. The first phase starts with a long hold-off on the
        // result side while samples keep coming.
        sent = 0;
        scans = 0;
        hold_cycles = 4000;
        while (sent < 850)
        begin
            if (scans % 8 == 0 && scans != 0)
            begin
                drain_results();
                case ($urandom_range(5))
                    0: write_windows(15'd0, 15'd0, 15'd0, 15'($urandom_range(1)));
                    1: write_windows(15'd18000, 15'd18000, 15'd18000, 15'd1);
                    2: write_windows(15'd5000, 15'd8000, 15'd4000, 15'($urandom_range(1)));
                    3: write_windows(CENTER_LIMIT_RST, SIDE_LOWER_RST, SIDE_UPPER_RST, 15'd0);
                    default:
                        write_windows(15'($urandom_range(6000)), 15'($urandom_range(9000)),
                                      15'($urandom_range(18000)), 15'($urandom_range(1)));
                endcase
            end
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 30) : $urandom_range(24, 1);
            for (int i = 0; i < len; i++)
                send_sample(draw_angle(), draw_value(), 1'($urandom),
                            i == len - 1, 0, none, 1);
            sent += len;
            scans++;
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast <= 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
